// File: rtl/core/smsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding median spike detector package
// Shared field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package smsd_pkg;

  // Fixed widths of the port fields.
  localparam int unsigned AmountW   = 8;
  localparam int unsigned CfgW      = 11;
  localparam int unsigned AlertCntW = 32;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } smsd_state_e;

endpackage

// File: rtl/core/smsd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram bin cell
// Holds the count of one value bin. A cumulative-sum token passes through the
// cell each cycle; the cell adds its count and marks the two median ranks.
// ----------------------------------------------------------------------------
module smsd_cell #(
  parameter int unsigned Index = 0,
  parameter int unsigned BinW  = 8,
  parameter int unsigned CntW  = 11
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // Histogram maintenance.
  input  logic            clr_i,
  input  logic            inc_en_i,
  input  logic [BinW-1:0] inc_bin_i,
  input  logic            dec_en_i,
  input  logic [BinW-1:0] dec_bin_i,
  // Ranks searched for during the walk.
  input  logic [CntW-1:0] rank_lo_i,
  input  logic [CntW-1:0] rank_hi_i,
  // Token from the previous cell.
  input  logic            tok_valid_i,
  input  logic [CntW-1:0] tok_sum_i,
  input  logic            lo_found_i,
  input  logic [BinW-1:0] lo_bin_i,
  input  logic            hi_found_i,
  input  logic [BinW-1:0] hi_bin_i,
  // Token to the next cell.
  output logic            tok_valid_o,
  output logic [CntW-1:0] tok_sum_o,
  output logic            lo_found_o,
  output logic [BinW-1:0] lo_bin_o,
  output logic            hi_found_o,
  output logic [BinW-1:0] hi_bin_o
);

  localparam logic [BinW-1:0] MyBin = BinW'(Index);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            inc_hit, dec_hit;
  logic [CntW-1:0] sum_next;
  logic            lo_hit, hi_hit;

  logic            tok_valid_q;
  logic [CntW-1:0] tok_sum_q;
  logic            lo_found_q, hi_found_q;
  logic [BinW-1:0] lo_bin_q, hi_bin_q;

  // Count update: the oldest sample leaves, the new sample enters.
  assign inc_hit = inc_en_i && (inc_bin_i == MyBin);
  assign dec_hit = dec_en_i && (dec_bin_i == MyBin) && (cnt_q != '0);

  always_comb begin
    cnt_d = cnt_q;
    if (clr_i) begin
      cnt_d = '0;
    end else begin
      if (dec_hit) cnt_d = cnt_d - CntW'(1);
      if (inc_hit) cnt_d = cnt_d + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Cumulative sum and the first bin reaching each rank.
  assign sum_next = tok_sum_i + cnt_q;
  assign lo_hit   = !lo_found_i && (sum_next >= rank_lo_i);
  assign hi_hit   = !hi_found_i && (sum_next >= rank_hi_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_sum_q  <= sum_next;
    lo_found_q <= lo_found_i || lo_hit;
    hi_found_q <= hi_found_i || hi_hit;
    lo_bin_q   <= lo_hit ? MyBin : lo_bin_i;
    hi_bin_q   <= hi_hit ? MyBin : hi_bin_i;
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_sum_o   = tok_sum_q;
  assign lo_found_o  = lo_found_q;
  assign lo_bin_o    = lo_bin_q;
  assign hi_found_o  = hi_found_q;
  assign hi_bin_o    = hi_bin_q;

endmodule

// File: rtl/core/sliding_median_spike_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding median spike detector
// Flags a sample that is at least twice the median of the trailing window.
// ----------------------------------------------------------------------------
// Usage:
// Input transactions carry one sample on amount_i (in_valid_i / in_stall_o).
// Each input transaction yields exactly one output transaction with
// window_full_o, alert_o and alert_count_o (out_valid_o / out_stall_i).
// window_length_we_i writes the window length and restarts the window
// (histogram, fill level and pointer clear; the sample ring contents and
// the alert count are kept). Write it only while the block is idle.
// Timing: while the window is filling, an accepted sample goes straight to
// the finishing step, which loads the output register. Once the window is
// full, a token walks the chain of VALUE_BINS histogram cells, one cell per
// cycle, before the finishing step. No new sample is taken until the
// finishing step of the current one is done.
// A finished result sits in an output register; the next sample is taken
// while it waits, and the block holds that sample's result until the
// receiver drops out_stall_i.
// Reset clears the histogram cells at once (no clearing pass), sets the
// window length to 1 and the alert count to zero.
// ----------------------------------------------------------------------------
module sliding_median_spike_detector #(
  parameter int unsigned VALUE_BINS = 256,
  parameter int unsigned WINDOW_MAX = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration.
  input  logic                             window_length_we_i,
  input  logic [smsd_pkg::CfgW-1:0]        window_length_i,
  // Input channel.
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [smsd_pkg::AmountW-1:0]     amount_i,
  // Output channel.
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             window_full_o,
  output logic                             alert_o,
  output logic [smsd_pkg::AlertCntW-1:0]   alert_count_o
);

  localparam int unsigned BinW = $clog2(VALUE_BINS);
  localparam int unsigned CntW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned PtrW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CmpW = (BinW + 1 > smsd_pkg::AmountW) ? BinW + 1
                                                                 : smsd_pkg::AmountW;
  localparam int unsigned AmtW = smsd_pkg::AmountW;
  localparam int unsigned AcW  = smsd_pkg::AlertCntW;

  // Map a sample to its histogram bin, saturating at the top bin.
  function automatic logic [BinW-1:0] bin_of(input logic [AmtW-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    if (wide >= VALUE_BINS) begin
      return BinW'(VALUE_BINS - 1);
    end
    return BinW'(v);
  endfunction

  smsd_pkg::smsd_state_e state_q, state_d;

  logic [smsd_pkg::CfgW-1:0] len_q;
  logic [CntW-1:0]           len_eff;
  logic [CntW-1:0]           fill_q;
  logic [PtrW-1:0]           ptr_q;
  logic [PtrW-1:0]           ptr_eff;
  logic [CntW-1:0]           ptr_inc;
  logic [AcW-1:0]            alerts_q;

  logic [AmtW-1:0]           amount_q;
  logic                      full_q;
  logic                      start_q;
  logic [CntW-1:0]           rank_lo_q, rank_hi_q;
  logic [BinW:0]             twice_q;
  logic [AmtW-1:0]           oldest_q;

  logic                      out_valid_q;
  logic                      full_out_q, alert_out_q;

  logic                      in_fire;
  logic                      done_fire;
  logic                      full_now;
  logic                      alert_now;
  logic                      tail_valid;

  // Effective window length, clamped to 1..WINDOW_MAX.
  always_comb begin
    if (len_q == '0) begin
      len_eff = CntW'(1);
    end else if (32'(len_q) > WINDOW_MAX) begin
      len_eff = CntW'(WINDOW_MAX);
    end else begin
      len_eff = CntW'(len_q);
    end
  end

  assign ptr_eff  = (CntW'(ptr_q) >= len_eff) ? '0 : ptr_q;
  assign ptr_inc  = CntW'(ptr_q) + CntW'(1);
  assign full_now = (fill_q >= len_eff);

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      smsd_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = full_now ? smsd_pkg::ST_WALK : smsd_pkg::ST_DONE;
      end
      smsd_pkg::ST_WALK: begin
        if (tail_valid) state_d = smsd_pkg::ST_DONE;
      end
      smsd_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = smsd_pkg::ST_IDLE;
      end
      default: state_d = smsd_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = (state_q != smsd_pkg::ST_IDLE);
    in_fire    = (state_q == smsd_pkg::ST_IDLE) && in_valid_i;
    done_fire  = (state_q == smsd_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smsd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Window control: length register, fill level, ring pointer, alert count.
  assign alert_now = full_q && (CmpW'(amount_q) >= CmpW'(twice_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= smsd_pkg::CfgW'(1);
      fill_q   <= '0;
      ptr_q    <= '0;
      alerts_q <= '0;
      start_q  <= 1'b0;
    end else begin
      start_q <= in_fire && full_now;
      if (window_length_we_i) begin
        len_q  <= window_length_i;
        fill_q <= '0;
        ptr_q  <= '0;
      end else if (in_fire) begin
        ptr_q <= ptr_eff;
      end else if (done_fire) begin
        ptr_q <= (ptr_inc >= len_eff) ? '0 : PtrW'(ptr_inc);
        if (!full_q) fill_q <= fill_q + CntW'(1);
        if (alert_now && (alerts_q != '1)) alerts_q <= alerts_q + AcW'(1);
      end
    end
  end

  // Per-transaction working registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      amount_q  <= amount_i;
      full_q    <= full_now;
      rank_hi_q <= (len_eff >> 1) + CntW'(1);
      rank_lo_q <= len_eff[0] ? (len_eff >> 1) + CntW'(1) : (len_eff >> 1);
    end
  end

  // Sample ring: read the oldest sample on acceptance, write the new one at the end.
  logic [AmtW-1:0] ring_mem [WINDOW_MAX];

  always_ff @(posedge clk_i) begin
    if (in_fire) oldest_q <= ring_mem[ptr_eff];
    if (done_fire) ring_mem[ptr_q] <= amount_q;
  end

  // Chain of histogram cells.
  logic            tok_valid [VALUE_BINS+1];
  logic [CntW-1:0] tok_sum   [VALUE_BINS+1];
  logic            lo_found  [VALUE_BINS+1];
  logic [BinW-1:0] lo_bin    [VALUE_BINS+1];
  logic            hi_found  [VALUE_BINS+1];
  logic [BinW-1:0] hi_bin    [VALUE_BINS+1];

  assign tok_valid[0] = start_q;
  assign tok_sum[0]   = '0;
  assign lo_found[0]  = 1'b0;
  assign lo_bin[0]    = '0;
  assign hi_found[0]  = 1'b0;
  assign hi_bin[0]    = '0;

  logic            upd_inc_en, upd_dec_en;
  logic [BinW-1:0] upd_inc_bin, upd_dec_bin;

  assign upd_inc_en  = done_fire;
  assign upd_inc_bin = bin_of(amount_q);
  assign upd_dec_en  = done_fire && full_q;
  assign upd_dec_bin = bin_of(oldest_q);

  for (genvar g = 0; g < VALUE_BINS; g++) begin : g_cell
    smsd_cell #(
      .Index(g),
      .BinW (BinW),
      .CntW (CntW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clr_i      (window_length_we_i),
      .inc_en_i   (upd_inc_en),
      .inc_bin_i  (upd_inc_bin),
      .dec_en_i   (upd_dec_en),
      .dec_bin_i  (upd_dec_bin),
      .rank_lo_i  (rank_lo_q),
      .rank_hi_i  (rank_hi_q),
      .tok_valid_i(tok_valid[g]),
      .tok_sum_i  (tok_sum[g]),
      .lo_found_i (lo_found[g]),
      .lo_bin_i   (lo_bin[g]),
      .hi_found_i (hi_found[g]),
      .hi_bin_i   (hi_bin[g]),
      .tok_valid_o(tok_valid[g+1]),
      .tok_sum_o  (tok_sum[g+1]),
      .lo_found_o (lo_found[g+1]),
      .lo_bin_o   (lo_bin[g+1]),
      .hi_found_o (hi_found[g+1]),
      .hi_bin_o   (hi_bin[g+1])
    );
  end

  assign tail_valid = tok_valid[VALUE_BINS];

  // Twice the median is the sum of the two middle-rank values.
  always_ff @(posedge clk_i) begin
    if ((state_q == smsd_pkg::ST_WALK) && tail_valid) begin
      twice_q <= (lo_found[VALUE_BINS] ? (BinW+1)'(lo_bin[VALUE_BINS]) : '0)
               + (hi_found[VALUE_BINS] ? (BinW+1)'(hi_bin[VALUE_BINS]) : '0);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      full_out_q  <= full_q;
      alert_out_q <= alert_now;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign window_full_o = full_out_q;
  assign alert_o       = alert_out_q;
  assign alert_count_o = alerts_q;

  // The walk token only leaves the chain while the sequencer waits for it.
  a_tail_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_valid |-> (state_q == smsd_pkg::ST_WALK))
    else $error("walk token left the chain outside the walk");

  // The fill level never passes the effective window length.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= len_eff)
    else $error("fill level above window length");

  // A result is only presented after the finishing step.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == smsd_pkg::ST_DONE))
    else $error("result appeared without a finished transaction");

  // An alert is only raised on a full window.
  a_alert_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && alert_o) |-> window_full_o)
    else $error("alert raised while the window was filling");

  // After an input transaction the block takes no other until it finishes.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("second input transaction taken during processing");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding median spike detector testbench
// Streams samples through the detector and predicts every output transaction
// with a local histogram model of the trailing window. A short directed part
// covers odd and even windows, zero medians, extreme samples and the special
// window lengths. Random phases follow, each with its own window length and
// idling mode. One phase holds the receiver off long enough to back the
// detector up. The all-ones length, which saturates to the largest window,
// is filled completely.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned AmountW   = smsd_pkg::AmountW;
  localparam int unsigned CfgW      = smsd_pkg::CfgW;
  localparam int unsigned AlertCntW = smsd_pkg::AlertCntW;

  localparam int unsigned NumBins   = 256;
  localparam int unsigned WindowCap = 1024;
  localparam int unsigned LongHold  = 1500;
  localparam int unsigned TailWait  = 300;
  localparam int unsigned NumPhases = 8;

  // Expected content of one output transaction.
  typedef struct packed {
    logic                 full;
    logic                 alert;
    logic [AlertCntW-1:0] count;
  } spike_result_t;

  // Clock and reset.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  // Signals driven into the detector.
  logic               cfg_we    = 1'b0;
  logic [CfgW-1:0]    cfg_len   = '0;
  logic               in_valid  = 1'b0;
  logic [AmountW-1:0] amount    = '0;
  logic               out_stall = 1'b0;

  // Signals driven by the detector.
  logic                 in_stall;
  logic                 out_valid;
  logic                 window_full;
  logic                 alert;
  logic [AlertCntW-1:0] alert_count;

  sliding_median_spike_detector dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .window_length_we_i (cfg_we),
    .window_length_i    (cfg_len),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .amount_i           (amount),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .window_full_o      (window_full),
    .alert_o            (alert),
    .alert_count_o      (alert_count)
  );

  // Stimulus and checking state.
  logic [AmountW-1:0] pending_amounts[$];
  spike_result_t      expected_results[$];
  int unsigned        send_idle_pct = 0;
  int unsigned        stall_pct     = 0;
  int unsigned        mismatches    = 0;
  logic               hold_armed    = 1'b0;
  logic               rx_hold       = 1'b0;

  // Local copy of the detector state.
  int unsigned        hist_bins[NumBins];
  logic [AmountW-1:0] sample_ring[WindowCap];
  int unsigned        held_samples;
  int unsigned        ring_slot;
  logic [CfgW-1:0]    window_setting;
  logic [AlertCntW-1:0] alert_total;

  // Restart the trailing window; the alert total survives.
  function automatic void clear_window();
    foreach (hist_bins[i]) hist_bins[i] = 0;
    held_samples = 0;
    ring_slot    = 0;
  endfunction

  // A zero length acts as one, anything above the ring depth as the ring depth.
  function automatic int unsigned window_span();
    if (window_setting == 0) return 1;
    if (window_setting > WindowCap) return WindowCap;
    return window_setting;
  endfunction

  // Value of the sample with the given 1-based rank in the window.
  function automatic int unsigned rank_value(int unsigned rank);
    int unsigned acc;
    acc = 0;
    for (int i = 0; i < NumBins; i++) begin
      acc += hist_bins[i];
      if (acc >= rank) return i;
    end
    return 0;
  endfunction

  // Result of one sample and the window update that follows it. Samples are
  // 8 bits wide, so every sample has a histogram bin of its own.
  function automatic spike_result_t predict_spike(logic [AmountW-1:0] smp);
    spike_result_t res;
    int unsigned   span;
    int unsigned   twice_median;
    span = window_span();
    res  = '0;
    if (ring_slot >= span) ring_slot = 0;
    if (held_samples >= span) begin
      res.full = 1'b1;
      if ((span % 2) != 0) begin
        twice_median = 2 * rank_value(span / 2 + 1);
      end else begin
        twice_median = rank_value(span / 2) + rank_value(span / 2 + 1);
      end
      if (smp >= twice_median) begin
        res.alert = 1'b1;
        if (alert_total != '1) alert_total++;
      end
      if (hist_bins[sample_ring[ring_slot]] > 0) hist_bins[sample_ring[ring_slot]]--;
    end else begin
      held_samples++;
    end
    hist_bins[smp]++;
    sample_ring[ring_slot] = smp;
    ring_slot++;
    if (ring_slot >= span) ring_slot = 0;
    res.count = alert_total;
    return res;
  endfunction

  // Mostly a quiet background with spikes, some full-range noise and zeros.
  function automatic logic [AmountW-1:0] draw_amount(int unsigned bg_hi);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) return AmountW'($urandom_range(bg_hi));
    if (pick < 75) return AmountW'($urandom_range(2 * bg_hi, NumBins - 1));
    if (pick < 92) return AmountW'($urandom_range(NumBins - 1));
    return '0;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Block until every pending sample is taken and every result has arrived.
  // Checked between clock edges, so the driver's updates have settled.
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_amounts.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  // Write the window length while the detector is idle.
  task automatic set_window(input logic [CfgW-1:0] len);
    wait_idle();
    @(posedge clk_i);
    cfg_we  <= 1'b1;
    cfg_len <= len;
    window_setting = len;
    clear_window();
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Choose one of the idling modes for the next phase.
  task automatic set_idling(input int unsigned mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 85; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 85; end
      default: begin send_idle_pct = 32; stall_pct = 32; end
    endcase
  endtask

  // Driver: predicts each accepted transaction and offers the next sample.
  always @(posedge clk_i) begin : feed
    logic taken;
    taken = in_valid && !in_stall;
    if (taken) expected_results.push_back(predict_spike(amount));
    if (!in_valid || taken) begin
      if (pending_amounts.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        amount   <= pending_amounts.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each output transaction with the oldest prediction.
  always @(posedge clk_i) begin : observe
    spike_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("output transaction with no sample pending");
      end else begin
        want = expected_results.pop_front();
        if (window_full !== want.full)
          report_mismatch($sformatf("window_full got %0b want %0b", window_full, want.full));
        if (alert !== want.alert)
          report_mismatch($sformatf("alert got %0b want %0b", alert, want.alert));
        if (alert_count !== want.count)
          report_mismatch($sformatf("alert_count got %0d want %0d", alert_count, want.count));
      end
    end
    out_stall <= rx_hold || ($urandom_range(99) < stall_pct);
  end

  // Long receiver hold-off, started once by the stimulus.
  initial begin : hold_off
    while (!hold_armed) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (LongHold) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Stimulus sequence.
  initial begin : stimulus
    int unsigned len;
    int unsigned span;
    int unsigned n_items;
    int unsigned bg_hi;
    int unsigned pick;

    window_setting = 1;
    alert_total    = '0;
    clear_window();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset length of one: each sample is compared with twice the one before.
    pending_amounts = '{8'd0, 8'd0, 8'd255, 8'd127, 8'd128, 8'd255, 8'd0, 8'd1,
                        8'd200, 8'd100};

    // A written length of zero behaves as one.
    set_window(0);
    pending_amounts = '{8'd5, 8'd10, 8'd9, 8'd255};

    // Even window: the two middle ranks are summed.
    set_window(2);
    pending_amounts = '{8'd10, 8'd20, 8'd30, 8'd50, 8'd0, 8'd255};

    // Odd window with a median that drops to zero.
    set_window(3);
    pending_amounts = '{8'd4, 8'd4, 8'd0, 8'd0, 8'd8};

    // Random phases, mostly short windows.
    for (int p = 0; p < NumPhases; p++) begin
      set_idling(p);
      pick = $urandom_range(99);
      if (pick < 25)      len = $urandom_range(0, 3);
      else if (pick < 80) len = $urandom_range(4, 16);
      else                len = $urandom_range(17, 60);
      set_window(CfgW'(len));
      span = window_span();
      bg_hi = $urandom_range(1, 60);
      n_items = span + $urandom_range(35, 60);
      // Now and then restart the window before it has filled.
      if (p % 5 == 4) n_items = $urandom_range(1, span);
      if (p == 1) hold_armed = 1'b1;
      repeat (n_items) pending_amounts.push_back(draw_amount(bg_hi));
    end

    // Largest legal window for a short while, then the all-ones length that
    // saturates to it, filled completely.
    set_idling(1);
    set_window(CfgW'(WindowCap));
    bg_hi = $urandom_range(1, 60);
    repeat (20) pending_amounts.push_back(draw_amount(bg_hi));
    set_idling(3);
    set_window('1);
    bg_hi = $urandom_range(1, 60);
    repeat (WindowCap + 20) pending_amounts.push_back(draw_amount(bg_hi));

    wait_idle();
    repeat (TailWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("sliding_median_spike_detector regression: pass");
    end else begin
      $display("sliding_median_spike_detector regression: fail");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin : watchdog
    #50_000_000;
    $display("sliding_median_spike_detector regression: fail");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/smsd_pkg.sv
rtl/core/smsd_cell.sv
rtl/core/sliding_median_spike_detector.sv
sim/tb.sv
